// File: design/ptc_pkg.sv
`timescale 1ns / 1ps
// package for the pressure and temperature compensation block
// types, register codes and pipeline constants; no dependencies

package ptc_pkg;

  localparam int unsigned FRONT_STAGES = 11;
  localparam int unsigned DIV_STEPS    = 64;
  localparam int unsigned BACK_STAGES  = 7;
  localparam int unsigned LATENCY      = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 64;

  localparam logic signed [31:0] TF_OFFSET   = 32'sd128000;
  localparam logic [20:0]        P_BASE      = 21'd1048576;
  localparam logic [31:0]        P_SCALE     = 32'd3125;
  localparam logic [63:0]        A_BIAS      = 64'h0000_8000_0000_0000;

  typedef enum logic [1:0] {
    REG_TEMP       = 2'd0,
    REG_PRESS_A    = 2'd1,
    REG_PRESS_B    = 2'd2,
    REG_PRESS_NINE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_error;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic               neg;
    logic               err;
    logic signed [15:0] temp;
  } div_side_t;

endpackage

// File: design/ptc_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// depends on ptc_pkg

module ptc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [63:0]         dividend,
  input  logic [30:0]         divisor,
  input  ptc_pkg::div_side_t  side_in,
  output logic [63:0]         quotient,
  output ptc_pkg::div_side_t  side_out
);
  import ptc_pkg::*;

  logic [30:0] rem_r  [DIV_STEPS];
  logic [63:0] work_r [DIV_STEPS];
  logic [30:0] dvsr_r [DIV_STEPS];
  div_side_t   side_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [30:0] rem_i;
    logic [63:0] work_i;
    logic [30:0] dvsr_i;
    div_side_t   side_i;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign work_i = dividend;
      assign dvsr_i = divisor;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign work_i = work_r[k-1];
      assign dvsr_i = dvsr_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = {rem_i, work_i[63]};
    assign ge    = trial >= {1'b0, dvsr_i};
    assign diff  = trial - {1'b0, dvsr_i};

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? diff[30:0] : trial[30:0];
      work_r[k] <= {work_i[62:0], ge};
      dvsr_r[k] <= dvsr_i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else begin
        side_r[k] <= side_i;
      end
    end
  end

  assign quotient = work_r[DIV_STEPS-1];
  assign side_out = side_r[DIV_STEPS-1];

endmodule

// File: design/pressure_temperature_compensation.sv
`timescale 1ns / 1ps
// top level of the pressure and temperature compensation pipeline
// depends on ptc_pkg and ptc_div

// Fully pipelined: one request (raw temperature and raw pressure) can be
// started in every clock cycle, and each gives exactly one result on
// out_data, marked by out_valid for one cycle. The pipeline has 11 front
// stages for the fine temperature and the divisor and dividend, a 64-stage
// divider that yields one quotient bit per stage, and 7 stages for the
// pressure correction and saturation. The receiver cannot hold results off.
// busy is high only during reset. The user must write coefficients over the
// register port only while no request is in flight; the block itself does
// not enforce this.

module pressure_temperature_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ptc_pkg::in_t                   in_data,
  output logic                           out_valid,
  output ptc_pkg::out_t                  out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptc_pkg::CFG_AW-1:0]     paddr,
  input  logic [ptc_pkg::CFG_DW-1:0]     pwdata,
  output logic [ptc_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);
  import ptc_pkg::*;

  // configuration registers
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_nine_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_nine_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEMP:       temp_coeffs_r <= pwdata[47:0];
        REG_PRESS_A:    press_a_r     <= pwdata;
        REG_PRESS_B:    press_b_r     <= pwdata;
        REG_PRESS_NINE: press_nine_r  <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TEMP:       prdata = {16'b0, temp_coeffs_r};
      REG_PRESS_A:    prdata = press_a_r;
      REG_PRESS_B:    prdata = press_b_r;
      REG_PRESS_NINE: prdata = {48'b0, press_nine_r};
      default:        prdata = '0;
    endcase
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs_r[15:0];
  assign t2 = temp_coeffs_r[31:16];
  assign t3 = temp_coeffs_r[47:32];
  assign p1 = press_a_r[15:0];
  assign p2 = press_a_r[31:16];
  assign p3 = press_a_r[47:32];
  assign p4 = press_a_r[63:48];
  assign p5 = press_b_r[15:0];
  assign p6 = press_b_r[31:16];
  assign p7 = press_b_r[47:32];
  assign p8 = press_b_r[63:48];
  assign p9 = press_nine_r;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start && !busy;

  // front pipeline
  logic [FRONT_STAGES-1:1] fv_r;
  logic [19:0]             adcp_r [1:7];
  logic signed [15:0]      tempc_r [5:10];

  logic signed [18:0] d1;
  logic signed [17:0] d2;
  logic signed [35:0] d2sq;
  logic signed [34:0] d1t2_r;
  logic [34:0]        dsq_r;

  logic signed [34:0] d1t2_sh;
  logic signed [23:0] tfa_r;
  logic signed [39:0] dt3_r;
  logic signed [39:0] dt3_sh;
  logic signed [31:0] tf_r;
  logic signed [31:0] a_r;
  logic signed [31:0] tt_r;
  logic signed [31:0] t5;

  logic signed [63:0] aa_full;
  logic signed [52:0] aa_r;
  logic signed [47:0] ap5_r, ap2_r;
  logic signed [68:0] pr6, pr3;
  logic signed [63:0] aap6_r, aap3_r;
  logic signed [47:0] ap5_6_r, ap2_6_r;
  logic [63:0]        b_r, a1_r;
  logic [63:0]        s_r, dv_r;
  logic [20:0]        pv;
  logic [47:0]        mlo_r;
  logic [31:0]        mhi_r;
  logic [43:0]        dlo_r;
  logic [31:0]        dhi_r;
  logic [63:0]        m_r, dd_r;
  logic signed [15:0] temp_nxt;

  assign d1 = $signed({2'b00, in_data.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
  assign d2 = $signed({2'b00, in_data.raw_temperature[19:4]}) - $signed({2'b00, t1});
  assign d2sq    = d2 * d2;
  assign d1t2_sh = d1t2_r >>> 11;
  assign dt3_sh  = dt3_r >>> 14;
  assign t5      = (tf_r <<< 2) + tf_r + 32'sd128;
  assign aa_full = a_r * a_r;
  assign pr6     = aa_r * p6;
  assign pr3     = aa_r * p3;
  assign pv      = P_BASE - {1'b0, adcp_r[7]};

  always_comb begin
    if (tt_r < -32'sd32768) begin
      temp_nxt = 16'sh8000;
    end else if (tt_r > 32'sd32767) begin
      temp_nxt = 16'sh7fff;
    end else begin
      temp_nxt = tt_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[FRONT_STAGES-2:1], accept};
    end
  end

  always_ff @(posedge clk) begin
    adcp_r[1] <= in_data.raw_pressure;
    for (int k = 2; k <= 7; k++) begin
      adcp_r[k] <= adcp_r[k-1];
    end
    tempc_r[5] <= temp_nxt;
    for (int k = 6; k <= 10; k++) begin
      tempc_r[k] <= tempc_r[k-1];
    end
    // fine temperature
    d1t2_r <= d1 * t2;
    dsq_r  <= d2sq[34:0];
    tfa_r  <= d1t2_sh[23:0];
    dt3_r  <= $signed({1'b0, dsq_r[34:12]}) * t3;
    tf_r   <= 32'(tfa_r) + 32'($signed(dt3_sh[25:0]));
    a_r    <= tf_r - TF_OFFSET;
    tt_r   <= t5 >>> 8;
    // pressure divisor and dividend
    aa_r    <= aa_full[52:0];
    ap5_r   <= a_r * p5;
    ap2_r   <= a_r * p2;
    aap6_r  <= pr6[63:0];
    aap3_r  <= pr3[63:0];
    ap5_6_r <= ap5_r;
    ap2_6_r <= ap2_r;
    b_r     <= aap6_r + (64'(ap5_6_r) <<< 17) + (64'(p4) <<< 35);
    a1_r    <= (aap3_r >>> 8) + (64'(ap2_6_r) <<< 12);
    s_r     <= A_BIAS + a1_r;
    dv_r    <= {12'b0, pv, 31'b0} - b_r;
    mlo_r   <= s_r[31:0] * p1;
    mhi_r   <= s_r[63:32] * {16'b0, p1};
    dlo_r   <= dv_r[31:0] * P_SCALE[11:0];
    dhi_r   <= dv_r[63:32] * P_SCALE;
    m_r     <= {16'b0, mlo_r} + {mhi_r, 32'b0};
    dd_r    <= {20'b0, dlo_r} + {dhi_r, 32'b0};
  end

  // divider input stage
  logic [30:0]  a3;
  logic [63:0]  ua_r;
  logic [30:0]  ub_r;
  div_side_t    dside_r;
  logic [63:0]  quot;
  div_side_t    qside;

  assign a3 = m_r[63:33];

  always_ff @(posedge clk) begin
    ua_r <= dd_r[63] ? (~dd_r + 64'd1) : dd_r;
    ub_r <= a3[30] ? (~a3 + 31'd1) : a3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dside_r <= '0;
    end else begin
      dside_r <= '{valid: fv_r[FRONT_STAGES-1], neg: dd_r[63] ^ a3[30],
                   err: (a3 == '0), temp: tempc_r[10]};
    end
  end

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .dividend (ua_r),
    .divisor  (ub_r),
    .side_in  (dside_r),
    .quotient (quot),
    .side_out (qside)
  );

  // back pipeline
  logic [BACK_STAGES:1] bv_r;
  logic signed [15:0]   btemp_r [1:6];
  logic                 berr_r  [1:6];
  logic [63:0]          qn_r    [1:4];

  logic signed [63:0] psw;
  logic signed [50:0] ps;
  logic signed [66:0] xprod;
  logic [63:0]        x_r;
  logic signed [50:0] ps_r;
  logic [31:0]        p8x;
  logic signed [48:0] elo_r;
  logic [31:0]        ehi_r;
  logic [63:0]        psx;
  logic [63:0]        e_r, ll_r;
  logic [31:0]        cr1_r, cr2_r;
  logic signed [63:0] cfull;
  logic signed [63:0] c_r, es_r;
  logic signed [63:0] sum_r, pf_r;
  out_t               out_nxt;

  assign psw   = $signed(qn_r[1]) >>> 13;
  assign ps    = psw[50:0];
  assign xprod = ps * p9;
  assign p8x   = 32'(p8);
  assign psx   = 64'(ps_r);
  assign cfull = $signed(ll_r + {cr1_r + cr2_r, 32'b0});

  always_comb begin
    out_nxt.temperature_centi = btemp_r[6];
    out_nxt.divide_error      = berr_r[6];
    if (berr_r[6] || pf_r[63]) begin
      out_nxt.pressure_q24_8 = '0;
    end else if (pf_r[63:32] != '0) begin
      out_nxt.pressure_q24_8 = '1;
    end else begin
      out_nxt.pressure_q24_8 = pf_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else begin
      bv_r <= {bv_r[BACK_STAGES-1:1], qside.valid};
    end
  end

  always_ff @(posedge clk) begin
    btemp_r[1] <= qside.temp;
    berr_r[1]  <= qside.err;
    for (int k = 2; k <= 6; k++) begin
      btemp_r[k] <= btemp_r[k-1];
      berr_r[k]  <= berr_r[k-1];
    end
    qn_r[1] <= qside.neg ? (~quot + 64'd1) : quot;
    for (int k = 2; k <= 4; k++) begin
      qn_r[k] <= qn_r[k-1];
    end
    x_r    <= xprod[63:0];
    ps_r   <= ps;
    elo_r  <= $signed({1'b0, qn_r[1][31:0]}) * p8;
    ehi_r  <= qn_r[1][63:32] * p8x;
    e_r    <= 64'(elo_r) + {ehi_r, 32'b0};
    ll_r   <= x_r[31:0] * psx[31:0];
    cr1_r  <= x_r[31:0] * psx[63:32];
    cr2_r  <= x_r[63:32] * psx[31:0];
    c_r    <= cfull >>> 25;
    es_r   <= $signed(e_r) >>> 19;
    sum_r  <= $signed(qn_r[4]) + c_r + es_r;
    pf_r   <= (sum_r >>> 8) + (64'(p7) <<< 4);
    out_data <= out_nxt;
  end

  assign out_valid = bv_r[BACK_STAGES];

  a_fwd_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("request did not give a result after the pipeline latency");

  a_bwd_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching request");

  a_div_err : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_error) |-> (out_data.pressure_q24_8 == '0))
    else $error("zero divisor result carries nonzero pressure");

  a_div_flag : assert property (@(posedge clk) disable iff (!rst_n)
    dside_r.valid |-> (dside_r.err == $past(m_r[63:33] == '0)))
    else $error("divide error flag does not follow the divisor");

endmodule

// File: tb/sv/ptc_checker.sv
`timescale 1ns / 1ps
// checker for the pressure and temperature compensation block
// watches the register port and both channels, predicts results; depends on ptc_pkg

module ptc_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  ptc_pkg::in_t               in_data,
  input  logic                       out_valid,
  input  ptc_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ptc_pkg::CFG_AW-1:0] paddr,
  input  logic [ptc_pkg::CFG_DW-1:0] pwdata,
  output int                         fail_count,
  output int                         pending_count,
  output int                         result_count,
  output int                         div_error_count
);
  import ptc_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_a;
  logic [63:0] press_b;
  logic [15:0] press_nine;
  out_t        expected_q[$];

  function automatic logic signed [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic out_t compensate(in_t req);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] d1, d2, tf, t, a, b, c, e, p, num, qa;
    logic [63:0] ua, ub;
    out_t r;
    t1 = {48'd0, temp_coeffs[15:0]};
    t2 = sx16(temp_coeffs[31:16]);
    t3 = sx16(temp_coeffs[47:32]);
    p1 = {48'd0, press_a[15:0]};
    p2 = sx16(press_a[31:16]);
    p3 = sx16(press_a[47:32]);
    p4 = sx16(press_a[63:48]);
    p5 = sx16(press_b[15:0]);
    p6 = sx16(press_b[31:16]);
    p7 = sx16(press_b[47:32]);
    p8 = sx16(press_b[63:48]);
    p9 = sx16(press_nine);
    d1 = $signed({44'd0, req.raw_temperature} >> 3) - (t1 <<< 1);
    d2 = $signed({44'd0, req.raw_temperature} >> 4) - t1;
    tf = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
    t = (tf * 5 + 128) >>> 8;
    if (t < -64'sd32768) r.temperature_centi = 16'sh8000;
    else if (t > 64'sd32767) r.temperature_centi = 16'sh7fff;
    else r.temperature_centi = t[15:0];
    a = tf - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.pressure_q24_8 = '0;
      r.divide_error = 1'b1;
    end else begin
      p = 64'sd1048576 - $signed({44'd0, req.raw_pressure});
      num = ((p <<< 31) - b) * 64'sd3125;
      ua = num[63] ? -num : num;
      ub = a[63] ? -a : a;
      qa = $signed(ua / ub);
      p = (num[63] != a[63]) ? -qa : qa;
      c = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      e = (p8 * p) >>> 19;
      p = ((p + c + e) >>> 8) + (p7 <<< 4);
      if (p < 0) r.pressure_q24_8 = '0;
      else if (p > 64'sh0ffff_ffff) r.pressure_q24_8 = 32'hffff_ffff;
      else r.pressure_q24_8 = p[31:0];
      r.divide_error = 1'b0;
    end
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      temp_coeffs <= '0;
      press_a <= '0;
      press_b <= '0;
      press_nine <= '0;
      fail_count <= 0;
      result_count <= 0;
      div_error_count <= 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:3]))
          REG_TEMP:       temp_coeffs <= pwdata[47:0];
          REG_PRESS_A:    press_a <= pwdata;
          REG_PRESS_B:    press_b <= pwdata;
          REG_PRESS_NINE: press_nine <= pwdata[15:0];
          default:        ;
        endcase
      end
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request waiting: %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.divide_error) div_error_count <= div_error_count + 1;
          if (want.temperature_centi !== out_data.temperature_centi ||
              want.pressure_q24_8 !== out_data.pressure_q24_8 ||
              want.divide_error !== out_data.divide_error) begin
            $display("%0t: mismatch expected temp %0d press %0h err %0b, got %0d %0h %0b",
                     $time, want.temperature_centi, want.pressure_q24_8,
                     want.divide_error, out_data.temperature_centi,
                     out_data.pressure_q24_8, out_data.divide_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(compensate(in_data));
    end
  end

endmodule

// File: tb/sv/pressure_temperature_compensation_test.sv
`timescale 1ns / 1ps
// testbench top for the pressure and temperature compensation block
// drives requests and register writes; depends on ptc_pkg, ptc_checker and the block

module pressure_temperature_compensation_test;
  import ptc_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_t                 in_data = '0;
  logic                out_valid;
  out_t                out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  int                  fail_count, pending_count, result_count, div_error_count;
  int                  sent;

  always #2 clk = ~clk;

  pressure_temperature_compensation DUT (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ptc_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending_count, .result_count, .div_error_count
  );

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_coeffs(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                             logic [15:0] p9);
    write_reg(REG_TEMP, {16'd0, tc});
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_NINE, {48'd0, p9});
  endtask

  // one request; gap is skipped in calm stretches
  task automatic send_request(logic [19:0] rt, logic [19:0] rp, bit calm);
    if (!calm) begin
      while ($urandom_range(99) < 17) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_data <= '{raw_temperature: rt, raw_pressure: rp};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_raw(int mode);
    case (mode)
      0: return 20'($urandom_range(20'hfffff));
      1: return 20'($urandom_range(20'h70000, 20'h88000));
      default: return 20'($urandom_range(20'h50000, 20'h60000));
    endcase
  endfunction

  initial begin
    logic [19:0] edge_vals[4];
    edge_vals = '{20'd0, 20'hfffff, 20'h80000, 20'h7ffff};
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: divisor is zero
    send_request(20'd0, 20'd0, 1'b1);
    send_request(20'hfffff, 20'hfffff, 1'b1);
    drain();

    // typical datasheet-like coefficients
    load_coeffs({16'hfc18, 16'h6810, 16'd27504},
                {16'h0af5, 16'hd0d0, 16'h0bd1, 16'd36477},
                {16'h0fa0, 16'hc8ec, 16'h3c62, 16'hff7f}, 16'h1770);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) send_request(edge_vals[i], edge_vals[j], 1'b0);
    send_request(20'd519888, 20'd415148, 1'b1);
    drain();

    // extremes of all coefficients
    load_coeffs('1, '1, '1, 16'h7fff);
    send_request(20'd0, 20'hfffff, 1'b0);
    send_request(20'hfffff, 20'd0, 1'b0);
    drain();
    load_coeffs({16'h8000, 16'h8000, 16'hffff}, {4{16'h8000}}, {4{16'h7fff}}, 16'h8000);
    send_request(20'd0, 20'd0, 1'b0);
    send_request(20'hfffff, 20'hfffff, 1'b0);
    send_request(20'h12345, 20'h6789a, 1'b0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 3 == 2)
        load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom));
      else
        load_coeffs({16'($urandom_range(16'h8000)) | 16'hfc00,
                     16'($urandom_range(16'h7000, 16'h6000)), 16'($urandom_range(20000, 40000))},
                    {16'($urandom_range(4095)), 16'($urandom_range(16'hd800, 16'hcc00)) ,
                     16'($urandom_range(4000)), 16'($urandom_range(30000, 40000))},
                    {16'($urandom_range(16'hffc0, 16'hff00)), 16'($urandom_range(16000)),
                     16'($urandom_range(16'hcc00, 16'hc400)), 16'($urandom_range(16000))},
                    16'($urandom_range(8000)));
      for (int k = 0; k < 98; k++)
        send_request(rand_raw(phase % 3 == 2 ? 0 : $urandom_range(2)),
                     rand_raw($urandom_range(2)), phase == 4);
      drain();
    end

    $display("requests sent %0d, results checked %0d, zero-divisor results %0d",
             sent, result_count, div_error_count);
    $display("coefficient sets: reset, typical, all extremes and random");
    if (fail_count == 0)
      $display("PASS pressure_temperature_compensation");
    else
      $display("FAIL pressure_temperature_compensation");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL pressure_temperature_compensation");
    $finish;
  end

endmodule

// File: pressure_temperature_compensation.f
design/ptc_pkg.sv
design/ptc_div.sv
design/pressure_temperature_compensation.sv
tb/sv/ptc_checker.sv
tb/sv/pressure_temperature_compensation_test.sv
